>>> hdl/npa_pkg.sv
package npa_pkg;

   // pool geometry
   localparam int MAX_IDS    = 1024;
   localparam int WORD_W     = 32;
   localparam int NUM_WORDS  = MAX_IDS / WORD_W;
   localparam int BIT_IDX_W  = $clog2(WORD_W);
   localparam int ROW_W      = $clog2(NUM_WORDS);

   // transaction field widths
   localparam int OPCODE_W   = 2;
   localparam int NUMBER_W   = 10;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 11;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [COUNT_W-1:0] MAX_IDS_CNT = COUNT_W'(MAX_IDS);
   localparam logic [COUNT_W-1:0] POOL_SIZE_RESET = COUNT_W'(1024);

   // register addresses
   localparam logic [CSR_ADDR_W-1:0] ADDR_POOL_SIZE = 2'd0;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_GET     = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_CHECK   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_GRANTED      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NONE_FREE    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_IS_FREE      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_IN_USE       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RELEASED     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd5;
   localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 3'd6;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic execute;
      logic clear;
   } npa_cmd_type;

   // pool size written to the register, saturated to the capacity
   function automatic logic [COUNT_W-1:0] effective_size(input logic [COUNT_W-1:0] size);
      effective_size = (size > MAX_IDS_CNT) ? MAX_IDS_CNT : size;
   endfunction

endpackage

>>> hdl/number_pool_allocator_core.sv
// Identifier pool allocator: hands out the lowest free identifier below the
// pool size (get), reports whether an identifier is free (check) and frees an
// identifier in use (release). In every transaction the cycle that accepts
// it reads one 32-bit word of the bitmap memory, chosen by a summary of full
// words for a get, and the next cycle resolves the request and writes the
// word back while busy is high. The result appears on the rsp_ ports for
// exactly one cycle, marked by rsp_strobe, the cycle after busy; it cannot be
// held off, and a new transaction may be started in that same cycle, so
// transactions can run back to back; none is accepted while busy. Writing
// pool_size (bits 10:0 kept; 1025-2047 count as 1024) frees the whole pool at
// once, with no clearing pass; rsp_free_count is the count after a transaction.
module number_pool_allocator_core
   import npa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [OPCODE_W-1:0]   req_opcode,
   input  logic [NUMBER_W-1:0]   req_number,
   output logic                  rsp_strobe,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [NUMBER_W-1:0]   rsp_granted_number,
   output logic [COUNT_W-1:0]    rsp_free_count,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   npa_cmd_type cmd;

   // sequencing
   npa_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .busy    (busy),
      .cmd     (cmd)
   );

   // bitmap, counters and result registers
   npa_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_opcode         (req_opcode),
      .req_number         (req_number),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_granted_number (rsp_granted_number),
      .rsp_free_count     (rsp_free_count)
   );

   assign pready = 1'b1;

endmodule

>>> hdl/npa_ram.sv
module npa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/npa_ctrl.sv
module npa_ctrl
   import npa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   output logic                  busy,
   output npa_cmd_type           cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   assign accept = start && (state_ff == ST_IDLE);

   // two-step sequence: read the bitmap word, then resolve and write back
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // command decode
   always_comb begin
      cmd.capture = accept;
      cmd.execute = (state_ff == ST_EXEC);
      cmd.clear   = psel && penable && pwrite && (paddr == ADDR_POOL_SIZE);
   end

   assign busy = (state_ff == ST_EXEC);

endmodule

>>> hdl/npa_dpath.sv
module npa_dpath
   import npa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  npa_cmd_type           cmd,
   input  logic [OPCODE_W-1:0]   req_opcode,
   input  logic [NUMBER_W-1:0]   req_number,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  rsp_strobe,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [NUMBER_W-1:0]   rsp_granted_number,
   output logic [COUNT_W-1:0]    rsp_free_count
);

   // configuration and pool state
   logic [COUNT_W-1:0]   pool_size_ff;
   logic [COUNT_W-1:0]   free_total_ff;
   logic [COUNT_W-1:0]   free_total_in;
   logic [NUM_WORDS-1:0] row_valid_ff;
   logic [NUM_WORDS-1:0] word_full_ff;
   logic [COUNT_W-1:0]   eff_size;

   // captured transaction
   logic [OPCODE_W-1:0]  op_ff;
   logic [BIT_IDX_W-1:0] bit_ff;
   logic [ROW_W-1:0]     row_ff;
   logic                 row_valid_rd_ff;
   logic                 in_range_ff;

   // result registers
   logic                 strobe_ff;
   logic [STATUS_W-1:0]  status_ff;
   logic [STATUS_W-1:0]  status_in;
   logic [NUMBER_W-1:0]  granted_ff;
   logic [NUMBER_W-1:0]  granted_in;

   // lookup and write-back signals
   logic [ROW_W-1:0]     open_row;
   logic [ROW_W-1:0]     rd_row;
   logic [WORD_W-1:0]    rd_word;
   logic [WORD_W-1:0]    cur_word;
   logic [BIT_IDX_W-1:0] free_bit;
   logic [WORD_W-1:0]    new_word;
   logic                 wr_en;

   assign eff_size = effective_size(pool_size_ff);

   // lowest word of the summary that still has a free bit
   always_comb begin
      open_row = '0;
      for (int w = NUM_WORDS - 1; w >= 0; w--) begin
         if (!word_full_ff[w]) begin
            open_row = ROW_W'(w);
         end
      end
   end

   assign rd_row = (req_opcode == OP_GET) ? open_row : req_number[NUMBER_W-1 -: ROW_W];

   npa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (row_ff),
      .wr_data (new_word),
      .rd_en   (cmd.capture),
      .rd_addr (rd_row),
      .rd_data (rd_word)
   );

   // capture the transaction alongside the bitmap read
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff           <= req_opcode;
         bit_ff          <= req_number[BIT_IDX_W-1:0];
         row_ff          <= rd_row;
         row_valid_rd_ff <= row_valid_ff[rd_row];
         in_range_ff     <= {1'b0, req_number} < eff_size;
      end
   end

   // a word never written since the last clear reads as all free
   assign cur_word = row_valid_rd_ff ? rd_word : '0;

   // lowest free bit in the word
   always_comb begin
      free_bit = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (!cur_word[b]) begin
            free_bit = BIT_IDX_W'(b);
         end
      end
   end

   // resolve the request and the bitmap update
   always_comb begin
      status_in     = ST_OUT_OF_RANGE;
      granted_in    = '0;
      free_total_in = free_total_ff;
      new_word      = cur_word;
      wr_en         = 1'b0;
      case (op_ff)
         OP_GET: begin
            if (free_total_ff == '0) begin
               status_in = ST_NONE_FREE;
            end else begin
               status_in          = ST_GRANTED;
               granted_in         = {row_ff, free_bit};
               new_word[free_bit] = 1'b1;
               free_total_in      = free_total_ff - COUNT_W'(1);
               wr_en              = cmd.execute;
            end
         end
         OP_CHECK: begin
            if (in_range_ff) begin
               status_in = cur_word[bit_ff] ? ST_IN_USE : ST_IS_FREE;
            end
         end
         OP_RELEASE: begin
            if (in_range_ff) begin
               if (cur_word[bit_ff]) begin
                  status_in        = ST_RELEASED;
                  new_word[bit_ff] = 1'b0;
                  free_total_in    = free_total_ff + COUNT_W'(1);
                  wr_en            = cmd.execute;
               end else begin
                  status_in = ST_ALREADY_FREE;
               end
            end
         end
         default: status_in = ST_OUT_OF_RANGE;
      endcase
   end

   // pool state: a size write clears the pool at once
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff  <= POOL_SIZE_RESET;
         free_total_ff <= effective_size(POOL_SIZE_RESET);
         row_valid_ff  <= '0;
         word_full_ff  <= '0;
      end else if (cmd.clear) begin
         pool_size_ff  <= pwdata[COUNT_W-1:0];
         free_total_ff <= effective_size(pwdata[COUNT_W-1:0]);
         row_valid_ff  <= '0;
         word_full_ff  <= '0;
      end else if (wr_en) begin
         free_total_ff        <= free_total_in;
         row_valid_ff[row_ff] <= 1'b1;
         word_full_ff[row_ff] <= &new_word;
      end
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.execute;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff  <= status_in;
         granted_ff <= granted_in;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_granted_number = granted_ff;
   assign rsp_free_count     = free_total_ff;
   assign prdata             = {{(CSR_DATA_W - COUNT_W){1'b0}}, pool_size_ff};

endmodule
